FILE: hdl/key_debounce_repeat_macros.svh
// Assertion macros for the checker file of key_debounce_repeat.
// Plain text macros only; the user supplies clock, reset, property and message.
`ifndef KEY_DEBOUNCE_REPEAT_MACROS_SVH
`define KEY_DEBOUNCE_REPEAT_MACROS_SVH

// Assertion clocked on the rising edge, disabled while the active-low reset is low.
`define KDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, without a reset qualifier.
`define KDR_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/kdr_pkg.sv
// Package for key_debounce_repeat: widths, op codes, register indexes.
// No dependencies.
`default_nettype none

package kdr_pkg;

  localparam int unsigned KeysW   = 8;
  localparam int unsigned TickW   = 8;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  localparam logic [KeysW-1:0] RepeatMaskRst  = KeysW'(6);
  localparam logic [TickW-1:0] RepeatStartRst = TickW'(50);
  localparam logic [TickW-1:0] RepeatNextRst  = TickW'(20);

  typedef enum logic [OpW-1:0] {
    OpTick   = 3'd0,
    OpPress  = 3'd1,
    OpRepeat = 3'd2,
    OpState  = 3'd3,
    OpShort  = 3'd4,
    OpLong   = 3'd5
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRepeatMask  = 2'd0,
    CfgRepeatStart = 2'd1,
    CfgRepeatNext  = 2'd2
  } cfg_e;

endpackage

`default_nettype wire

FILE: hdl/kdr_in_if.sv
// Input channel of key_debounce_repeat: valid/ready plus op, raw_keys, query_mask.
// Depends on kdr_pkg.
`default_nettype none

interface kdr_in_if;
  logic                       valid;
  logic                       ready;
  logic [kdr_pkg::OpW-1:0]    op;
  logic [kdr_pkg::KeysW-1:0]  raw_keys;
  logic [kdr_pkg::KeysW-1:0]  query_mask;

  modport source (output valid, output op, output raw_keys, output query_mask, input ready);
  modport sink   (input valid, input op, input raw_keys, input query_mask, output ready);
endinterface

`default_nettype wire

FILE: hdl/kdr_out_if.sv
// Result channel of key_debounce_repeat: valid/ready plus keys.
// Depends on kdr_pkg.
`default_nettype none

interface kdr_out_if;
  logic                      valid;
  logic                      ready;
  logic [kdr_pkg::KeysW-1:0] keys;

  modport source (output valid, output keys, input ready);
  modport sink   (input valid, input keys, output ready);
endinterface

`default_nettype wire

FILE: hdl/key_debounce_repeat.sv
// key_debounce_repeat: key debouncer with held-key autorepeat.
// Depends on kdr_pkg, kdr_in_if, kdr_out_if.
// Usage:
//   key_in_i carries one item per handshake: op, raw_keys, query_mask. op 0 is
//   a sample tick (raw_keys active low); ops 1..5 read press, repeat, state,
//   short, long press bits for keys in query_mask; all but state also clear.
//   key_out_o returns exactly one item per input item: keys.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 repeat mask, 1 repeat start ticks, 2 repeat next ticks); write only
//   while no item is in flight.
// Pipeline and throughput:
//   An accepted item is held in the entry register and moves to the result
//   register once that is empty or being taken. One item per
//   cycle is sustained while key_out_o is ready.
// Reset:
//   rst_ni clears all key state and loads the register defaults (6, 50, 20).
// Stall:
//   While key_out_o is stalled the result holds; one more item is taken into
//   the entry register, then key_in_i.ready drops until the result is taken.
`default_nettype none

module key_debounce_repeat (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  kdr_in_if.sink                             key_in_i,
  kdr_out_if.source                          key_out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [kdr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [kdr_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned KW = kdr_pkg::KeysW;
  localparam int unsigned TW = kdr_pkg::TickW;

  // configuration
  logic [KW-1:0] rep_mask_q;
  logic [TW-1:0] rep_start_q, rep_next_q;

  // key state
  logic [KW-1:0] deb_q, deb_d;
  logic [KW-1:0] press_q, press_d;
  logic [KW-1:0] rep_q, rep_d;
  logic [KW-1:0] cnt_lo_q, cnt_lo_d;
  logic [KW-1:0] cnt_hi_q, cnt_hi_d;
  logic [TW-1:0] cdown_q, cdown_d;

  // entry register
  logic                   in_vld_q;
  logic [kdr_pkg::OpW-1:0] op_q;
  logic [KW-1:0]          raw_q, sel_q;

  // result register
  logic          out_vld_q;
  logic [KW-1:0] keys_q, keys_d;

  logic advance;
  logic in_acc;

  // tick intermediates
  logic [KW-1:0] chg, tgl, held;
  logic [TW-1:0] cd_load, cd_dec;
  // query intermediates
  logic [KW-1:0] r_rep, r_press, sel_short;

  assign advance        = in_vld_q && (!out_vld_q || key_out_o.ready);
  assign key_in_i.ready = !in_vld_q || advance;
  assign in_acc         = key_in_i.valid && key_in_i.ready;

  assign key_out_o.valid = out_vld_q;
  assign key_out_o.keys  = keys_q;

  always_comb begin
    chg       = deb_q ^ ~raw_q;
    cnt_lo_d  = ~(cnt_lo_q & chg);
    cnt_hi_d  = cnt_lo_d ^ (cnt_hi_q & chg);
    tgl       = chg & cnt_lo_d & cnt_hi_d;
    held      = (deb_q ^ tgl) & rep_mask_q;
    cd_load   = (held == '0) ? rep_start_q : cdown_q;
    cd_dec    = cd_load - TW'(1);
    sel_short = sel_q & ~deb_q;
    r_rep     = sel_q & rep_q;
    r_press   = '0;

    deb_d   = deb_q;
    press_d = press_q;
    rep_d   = rep_q;
    cdown_d = cdown_q;
    keys_d  = '0;

    unique case (kdr_pkg::op_e'(op_q))
      kdr_pkg::OpTick: begin
        deb_d   = deb_q ^ tgl;
        press_d = press_q | (deb_d & tgl);
        if (cd_dec == '0) begin
          cdown_d = rep_next_q;
          rep_d   = rep_q | held;
        end else begin
          cdown_d = cd_dec;
        end
        keys_d  = deb_d;
      end
      kdr_pkg::OpPress: begin
        r_press = sel_q & press_q;
        press_d = press_q ^ r_press;
        keys_d  = r_press;
      end
      kdr_pkg::OpRepeat: begin
        rep_d  = rep_q ^ r_rep;
        keys_d = r_rep;
      end
      kdr_pkg::OpState: begin
        keys_d = sel_q & deb_q;
      end
      kdr_pkg::OpShort: begin
        r_press = sel_short & press_q;
        press_d = press_q ^ r_press;
        keys_d  = r_press;
      end
      kdr_pkg::OpLong: begin
        rep_d   = rep_q ^ r_rep;
        r_press = r_rep & press_q;
        press_d = press_q ^ r_press;
        keys_d  = r_press;
      end
      default: begin
        keys_d = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_mask_q  <= kdr_pkg::RepeatMaskRst;
      rep_start_q <= kdr_pkg::RepeatStartRst;
      rep_next_q  <= kdr_pkg::RepeatNextRst;
    end else if (cfg_we_i) begin
      unique case (kdr_pkg::cfg_e'(cfg_idx_i))
        kdr_pkg::CfgRepeatMask:  rep_mask_q  <= cfg_data_i[KW-1:0];
        kdr_pkg::CfgRepeatStart: rep_start_q <= cfg_data_i[TW-1:0];
        kdr_pkg::CfgRepeatNext:  rep_next_q  <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // key state, updated as an item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= '0;
      press_q  <= '0;
      rep_q    <= '0;
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
      cdown_q  <= '0;
    end else if (advance) begin
      deb_q   <= deb_d;
      press_q <= press_d;
      rep_q   <= rep_d;
      cdown_q <= cdown_d;
      if (kdr_pkg::op_e'(op_q) == kdr_pkg::OpTick) begin
        cnt_lo_q <= cnt_lo_d;
        cnt_hi_q <= cnt_hi_d;
      end
    end
  end

  // handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (key_out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= key_in_i.op;
      raw_q <= key_in_i.raw_keys;
      sel_q <= key_in_i.query_mask;
    end
    if (advance) begin
      keys_q <= keys_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kdr_checker.sv
// Port-level checks for key_debounce_repeat, bound to the top level.
// Depends on kdr_pkg and key_debounce_repeat_macros.svh.
`default_nettype none
`include "key_debounce_repeat_macros.svh"

module kdr_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [kdr_pkg::KeysW-1:0] out_keys_i
);

  `KDR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `KDR_ASSERT(a_keys_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_keys_i), "result changed while stalled")
  `KDR_ASSERT(a_ready_low, clk_i, rst_ni, !in_ready_i |-> out_valid_i && !out_ready_i, "input stalled without output stall")
  `KDR_ASSERT(a_result_due, clk_i, rst_ni, in_valid_i && in_ready_i |-> ##2 out_valid_i, "no result two cycles after item")

endmodule

bind key_debounce_repeat kdr_checker u_kdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (key_in_i.valid),
  .in_ready_i  (key_in_i.ready),
  .out_valid_i (key_out_o.valid),
  .out_ready_i (key_out_o.ready),
  .out_keys_i  (key_out_o.keys)
);

`default_nettype wire
